// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the deframer RTL; sampled on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset.
`define RED_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define RED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/red_pkg.sv -----
// ----------------------------------------------------------------------------
// red_pkg
// Types and constants of the record envelope deframer.
// ----------------------------------------------------------------------------
package red_pkg;

  localparam int FRAME_OVERHEAD = 10;
  localparam int HDR_BYTES      = 4;
  localparam int Q_DEPTH        = 2;
  localparam int POS_W          = 17;
  localparam int LEN_W          = 16;
  localparam int OFF_W          = 5;
  localparam int CNT_W          = 12;

  localparam logic [POS_W-1:0] POS_MAX      = '1;
  localparam logic [7:0]       MAGIC_BYTE   = 8'h5A;
  localparam logic [7:0]       CLASS_MARKER = 8'h0B;
  localparam logic [7:0]       CODE_MARKER  = 8'h01;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_STATUS = 1'b1
  } op_kind_t;

  typedef enum logic [1:0] {
    SLOT_NONE = 2'd0,
    SLOT_HDR  = 2'd1,
    SLOT_F0   = 2'd2,
    SLOT_F1   = 2'd3
  } slot_t;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_BAD_FRAME      = 2'd1,
    ST_BAD_LENGTH     = 2'd2,
    ST_COUNT_MISMATCH = 2'd3
  } status_t;

  typedef struct packed {
    op_kind_t         kind;
    slot_t            slot;
    logic             last;
    logic [7:0]       data;
    status_t          status;
    logic [CNT_W-1:0] total;
  } red_op_t;

  typedef struct packed {
    logic             kind;
    logic [CNT_W-1:0] record_index;
    logic [15:0]      seq_number;
    logic [31:0]      device_time;
    logic [7:0]       class_code;
    logic [7:0]       event_code;
    logic [31:0]      first_argument;
    logic [31:0]      second_argument;
    logic             is_marker;
    logic [1:0]       status;
    logic [CNT_W-1:0] total_records;
  } red_result_t;

endpackage

// ----- rtl/red_if.sv -----
// ----------------------------------------------------------------------------
// red_if
// Valid/ready channels of the deframer: byte input and result output.
// ----------------------------------------------------------------------------
interface red_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface red_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [11:0] record_index;
  logic [15:0] seq_number;
  logic [31:0] device_time;
  logic [7:0]  class_code;
  logic [7:0]  event_code;
  logic [31:0] first_argument;
  logic [31:0] second_argument;
  logic        is_marker;
  logic [1:0]  status;
  logic [11:0] total_records;

  modport source (output valid, kind, record_index, seq_number, device_time, class_code,
                  event_code, first_argument, second_argument, is_marker, status,
                  total_records, input ready);
  modport sink   (input valid, kind, record_index, seq_number, device_time, class_code,
                  event_code, first_argument, second_argument, is_marker, status,
                  total_records, output ready);
endinterface

// ----- rtl/red_front.sv -----
// ----------------------------------------------------------------------------
// red_front
// Byte intake: position tracking, header parse, record slotting and the
// envelope status check on the final byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module red_front #(
  parameter int RECORD_BYTES = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  red_in_if.sink           in_ch,
  input  logic             q_ready,
  output logic             push,
  output red_pkg::red_op_t push_op
);
  import red_pkg::*;

  localparam int DIV_SHIFT = LEN_W + $clog2(RECORD_BYTES);
  localparam int DIV_MULT  = (2**DIV_SHIFT + RECORD_BYTES - 1) / RECORD_BYTES;
  localparam int MUL_W     = LEN_W + 18;
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(RECORD_BYTES - 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             magic_r, magic_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [47:0]      recent_r, recent_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [POS_W-1:0] prod_r, prod_nxt;

  logic             acc;
  logic [47:0]      recent_shift;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] region_end;
  logic [MUL_W-1:0] div_prod;
  logic             head_ok;
  logic             tail_ok;
  status_t          st;

  assign acc          = in_ch.valid && q_ready;
  assign in_ch.ready  = q_ready;
  assign recent_shift = {recent_r[39:0], in_ch.data_byte};
  assign pos_inc      = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
  assign region_end   = POS_W'(HDR_BYTES) + {1'b0, len_r};

  // count = len / RECORD_BYTES by reciprocal, then count * RECORD_BYTES
  assign div_prod  = {{(MUL_W-LEN_W){1'b0}}, len_r} * MUL_W'(DIV_MULT);
  assign count_nxt = div_prod[DIV_SHIFT +: CNT_W];
  assign prod_nxt  = {{(POS_W-CNT_W){1'b0}}, count_r} * POS_W'(RECORD_BYTES);

  always_comb begin
    if (pos_r == POS_W'(0)) begin
      head_ok = 1'b0;
    end else if (pos_r == POS_W'(1)) begin
      head_ok = magic_r && (in_ch.data_byte == MAGIC_BYTE);
    end else begin
      head_ok = magic_r;
    end
    tail_ok = (recent_shift[15:0] == {MAGIC_BYTE, MAGIC_BYTE});
    if (pos_inc < POS_W'(FRAME_OVERHEAD) || !head_ok || !tail_ok) begin
      st = ST_BAD_FRAME;
    end else if (prod_r != {1'b0, len_r} ||
                 pos_inc != {1'b0, len_r} + POS_W'(FRAME_OVERHEAD)) begin
      st = ST_BAD_LENGTH;
    end else if (recent_shift[47:16] != {{(32-CNT_W){1'b0}}, count_r}) begin
      st = ST_COUNT_MISMATCH;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    magic_nxt  = magic_r;
    off_nxt    = off_r;
    recent_nxt = recent_r;
    push       = 1'b0;
    push_op.kind   = OP_RECORD;
    push_op.slot   = SLOT_NONE;
    push_op.last   = 1'b0;
    push_op.data   = in_ch.data_byte;
    push_op.status = st;
    push_op.total  = (st == ST_OK) ? count_r : '0;
    if (acc) begin
      if (in_ch.final_byte) begin
        push         = 1'b1;
        push_op.kind = OP_STATUS;
        pos_nxt      = '0;
        len_nxt      = '0;
        magic_nxt    = 1'b0;
        off_nxt      = '0;
        recent_nxt   = '0;
      end else begin
        pos_nxt    = pos_inc;
        recent_nxt = recent_shift;
        if (pos_r == POS_W'(0)) begin
          magic_nxt = (in_ch.data_byte == MAGIC_BYTE);
        end else if (pos_r == POS_W'(1)) begin
          magic_nxt = magic_r && (in_ch.data_byte == MAGIC_BYTE);
        end else if (pos_r == POS_W'(2)) begin
          len_nxt = {in_ch.data_byte, 8'h00};
        end else if (pos_r == POS_W'(3)) begin
          len_nxt = {len_r[15:8], in_ch.data_byte};
        end else if (pos_r < region_end) begin
          push = 1'b1;
          if (off_r < OFF_W'(8)) begin
            push_op.slot = SLOT_HDR;
          end else if (off_r < OFF_W'(16)) begin
            push_op.slot = SLOT_F0;
          end else if (off_r < OFF_W'(20)) begin
            push_op.slot = SLOT_F1;
          end
          if (off_r == OFF_LAST) begin
            push_op.last = 1'b1;
            off_nxt      = '0;
          end else begin
            off_nxt = off_r + OFF_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      len_r    <= '0;
      magic_r  <= 1'b0;
      off_r    <= '0;
      recent_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      magic_r  <= magic_nxt;
      off_r    <= off_nxt;
      recent_r <= recent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    prod_r  <= prod_nxt;
  end

  `RED_ASSERT_NEXT(a_final_clears, acc && in_ch.final_byte, pos_r == '0 && off_r == '0, "final byte did not clear position")
  `RED_ASSERT(a_off_range, off_r <= OFF_LAST, "record offset past record size")
  `RED_ASSERT(a_push_needs_room, !push || q_ready, "push into full queue")

endmodule

// ----- rtl/red_queue.sv -----
// ----------------------------------------------------------------------------
// red_queue
// Two-entry queue of classified byte operations between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module red_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  red_pkg::red_op_t push_op,
  output logic             q_ready,
  output logic             q_valid,
  input  logic             pop,
  output red_pkg::red_op_t pop_op
);
  import red_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_QW = $clog2(Q_DEPTH + 1);

  red_op_t            mem_r [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  cnt_r, cnt_nxt;

  assign q_ready = (cnt_r != CNT_QW'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign pop_op  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_QW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  `RED_ASSERT(a_no_underflow, !pop || q_valid, "pop from empty queue")
  `RED_ASSERT(a_cnt_range, cnt_r <= CNT_QW'(Q_DEPTH), "queue count out of range")
  `RED_ASSERT_NEXT(a_push_pop_hold, push && pop, cnt_r == $past(cnt_r), "count moved on push and pop")

endmodule

// ----- rtl/red_back.sv -----
// ----------------------------------------------------------------------------
// red_back
// Record assembly, record decode and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module red_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  red_pkg::red_op_t pop_op,
  output logic             pop,
  red_out_if.source        out_ch
);
  import red_pkg::*;

  logic [63:0]      hdr_r, hdr_nxt;
  logic [63:0]      f0_r, f0_nxt;
  logic [31:0]      f1_r, f1_nxt;
  logic [CNT_W-1:0] rec_done_r, rec_done_nxt;
  logic             out_valid_r, out_valid_nxt;
  red_result_t      res_r, res_nxt;
  logic             pop_status;
  logic             pop_last;

  assign pop        = q_valid && (!out_valid_r || out_ch.ready);
  assign pop_status = pop && (pop_op.kind == OP_STATUS);
  assign pop_last   = pop && (pop_op.kind == OP_RECORD) && pop_op.last;

  always_comb begin
    hdr_nxt       = hdr_r;
    f0_nxt        = f0_r;
    f1_nxt        = f1_r;
    rec_done_nxt  = rec_done_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;
    if (pop) begin
      if (pop_op.kind == OP_STATUS) begin
        rec_done_nxt          = '0;
        out_valid_nxt         = 1'b1;
        res_nxt               = '0;
        res_nxt.kind          = OP_STATUS;
        res_nxt.status        = pop_op.status;
        res_nxt.total_records = pop_op.total;
      end else begin
        unique case (pop_op.slot)
          SLOT_HDR:  hdr_nxt = {hdr_r[55:0], pop_op.data};
          SLOT_F0:   f0_nxt  = {f0_r[55:0], pop_op.data};
          SLOT_F1:   f1_nxt  = {f1_r[23:0], pop_op.data};
          SLOT_NONE: ;
          default:   ;
        endcase
        if (pop_op.last) begin
          out_valid_nxt           = 1'b1;
          rec_done_nxt            = rec_done_r + CNT_W'(1);
          res_nxt                 = '0;
          res_nxt.kind            = OP_RECORD;
          res_nxt.record_index    = rec_done_r;
          res_nxt.seq_number      = hdr_nxt[63:48];
          res_nxt.device_time     = hdr_nxt[31:0];
          res_nxt.class_code      = f0_nxt[63:56];
          res_nxt.event_code      = f0_nxt[39:32];
          res_nxt.first_argument  = f0_nxt[31:0];
          res_nxt.second_argument = f1_nxt;
          res_nxt.is_marker       = (f0_nxt[63:56] == CLASS_MARKER) &&
                                    (f0_nxt[39:32] == CODE_MARKER) &&
                                    (f0_nxt[31:0] == 32'd0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_done_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rec_done_r  <= rec_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
    f0_r  <= f0_nxt;
    f1_r  <= f1_nxt;
    res_r <= res_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.kind            = res_r.kind;
  assign out_ch.record_index    = res_r.record_index;
  assign out_ch.seq_number      = res_r.seq_number;
  assign out_ch.device_time     = res_r.device_time;
  assign out_ch.class_code      = res_r.class_code;
  assign out_ch.event_code      = res_r.event_code;
  assign out_ch.first_argument  = res_r.first_argument;
  assign out_ch.second_argument = res_r.second_argument;
  assign out_ch.is_marker       = res_r.is_marker;
  assign out_ch.status          = res_r.status;
  assign out_ch.total_records   = res_r.total_records;

  `RED_ASSERT_NEXT(a_status_clears, pop_status, rec_done_r == '0 && out_valid_r, "count not cleared")
  `RED_ASSERT_NEXT(a_rec_count, pop_last, rec_done_r == $past(rec_done_r) + CNT_W'(1), "no advance")
  `RED_ASSERT(a_no_overwrite, !pop || !out_valid_r || out_ch.ready, "pending result overwritten")

endmodule

// ----- rtl/record_envelope_deframer.sv -----
// ----------------------------------------------------------------------------
// record_envelope_deframer
// Byte-serial envelope deframer: emits one decoded item per completed record
// and one status item on the final byte of each envelope.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    data_byte, final_byte
//  out_ch    out  valid / ready    kind, record fields, status, total_records
//
//  One byte per cycle sustained unless out_ch stalls.
//  The front classifies each byte, a two-entry queue decouples it from the
//  back, which assembles records into a registered output item.
//  in_ch.ready drops only while the queue is full (output stalled).
//  rst_n is synchronous and active low; the block is ready in the first
//  cycle after it.
// ----------------------------------------------------------------------------
module record_envelope_deframer #(
  parameter int RECORD_BYTES = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  red_in_if.sink    in_ch,
  red_out_if.source out_ch
);
  import red_pkg::*;

  logic    push;
  red_op_t push_op;
  logic    q_ready;
  logic    q_valid;
  logic    pop;
  red_op_t pop_op;

  red_front #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .push    (push),
    .push_op (push_op)
  );

  red_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .q_ready (q_ready),
    .q_valid (q_valid),
    .pop     (pop),
    .pop_op  (pop_op)
  );

  red_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .pop_op  (pop_op),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
